>>> rtl/core/tlpt_pkg.sv
`timescale 1ns / 1ps
package tlpt_pkg;

  localparam int TABLE_SLOTS       = 16;
  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int IDX_W             = 10;
  localparam int OFF_W             = 12;
  localparam int FRAME_W           = 20;
  localparam int SLOT_W            = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W             = 11;
  localparam int DIR_DEPTH         = 1024;
  localparam int TAB_DEPTH         = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int TAB_AW            = $clog2(TAB_DEPTH);
  localparam int DIR_AW            = $clog2(DIR_DEPTH);
  localparam logic [IDX_W-1:0] MIRROR_RESET = 10'h3ff;

  typedef enum logic [1:0] {
    REQ_MAP   = 2'd0,
    REQ_UNMAP = 2'd1,
    REQ_XLATE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_NOMEM = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIR,
    S_TAB,
    S_UPD
  } state_e;

  typedef struct packed {
    logic              present;
    logic              write;
    logic              user;
    logic [SLOT_W-1:0] slot;
  } dir_ent_t;

  typedef struct packed {
    logic               present;
    logic               write;
    logic               user;
    logic [FRAME_W-1:0] frame;
  } tab_ent_t;

  localparam int DIR_W = $bits(dir_ent_t);
  localparam int TAB_W = $bits(tab_ent_t);

endpackage

>>> rtl/core/tlpt_ram.sv
`timescale 1ns / 1ps
module tlpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/two_level_page_table_manager.sv
`timescale 1ns / 1ps
// Channel  Handshake                Payload
// in       in_valid_i / in_ready_o  req_type, virt_addr, page_frame, user_page, write_allowed
// out      out_valid_o/ out_ready_i status, mapped, writable, phys_addr, released_*
// cfg      cfg_valid_i/ cfg_ready_o cfg_data_i (mirror directory index)
//
// Each request passes through accept, directory RAM read, table RAM read and
// update/writeback, in that order; each step depends on the one before it.
// After reset a clearing pass over every table RAM address zeroes both RAMs; no request
// is accepted meanwhile, config writes are. The update step stalls while the
// output register still holds an untaken result.
module two_level_page_table_manager
  import tlpt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tlpt_pkg::IDX_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                req_type_i,
  input  logic [31:0]               virt_addr_i,
  input  logic [tlpt_pkg::FRAME_W-1:0] page_frame_i,
  input  logic                      user_page_i,
  input  logic                      write_allowed_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic                      mapped_o,
  output logic                      writable_o,
  output logic [31:0]               phys_addr_o,
  output logic                      released_valid_o,
  output logic [tlpt_pkg::FRAME_W-1:0] released_frame_o
);

  state_e state_q, state_d;

  logic [IDX_W-1:0]   mirror_q;
  logic               clearing_q;
  logic [TAB_AW-1:0]  clr_cnt_q;

  logic [1:0]         req_q;
  logic [31:0]        va_q;
  logic [FRAME_W-1:0] frame_q;
  logic               user_q;
  logic               wr_q;

  logic [SLOT_W-1:0]  slot_q;
  logic               dpres_q;
  logic               dwrite_q;
  logic               hasfree_q;

  logic [TABLE_SLOTS-1:0] free_q;
  logic [CNT_W-1:0]       cnt_q [TABLE_SLOTS];

  logic               out_valid_q;
  logic [1:0]         status_q;
  logic               mapped_q, writable_q, rel_valid_q;
  logic [31:0]        phys_q;
  logic [FRAME_W-1:0] rel_frame_q;

  logic [DIR_W-1:0] dir_rdata;
  logic [TAB_W-1:0] tab_rdata;
  dir_ent_t         dir_ent;
  tab_ent_t         tab_ent;

  logic [IDX_W-1:0] di, ti;
  assign di = va_q[31:22];
  assign ti = va_q[21:12];

  // lowest free slot
  logic              has_free;
  logic [SLOT_W-1:0] free_idx;
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        has_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign dir_ent = dir_ent_t'(dir_rdata);
  assign tab_ent = tab_ent_t'(tab_rdata);

  logic [SLOT_W-1:0] slot_sel;
  assign slot_sel = dir_ent.present ? dir_ent.slot : free_idx;

  logic go;
  assign go = (state_q == S_UPD) && (!out_valid_q || out_ready_i);

  // update step
  logic               mirror_hit;
  logic [1:0]         res_status;
  logic               res_mapped, res_writable, res_rel;
  logic [31:0]        res_phys;
  logic               u_tab_we, u_dir_we, cnt_inc, cnt_dec, slot_take, slot_free;
  tab_ent_t           u_tab_wdata;
  dir_ent_t           u_dir_wdata;
  logic [CNT_W-1:0]   cnt_cur, cnt_less;

  assign mirror_hit = (di == mirror_q);
  assign cnt_cur    = cnt_q[slot_q];
  assign cnt_less   = (cnt_cur != '0) ? cnt_cur - CNT_W'(1) : '0;

  always_comb begin
    res_status   = ST_INVAL;
    res_mapped   = 1'b0;
    res_writable = 1'b0;
    res_rel      = 1'b0;
    res_phys     = '0;
    u_tab_we     = 1'b0;
    u_dir_we     = 1'b0;
    u_tab_wdata  = '0;
    u_dir_wdata  = '0;
    cnt_inc      = 1'b0;
    cnt_dec      = 1'b0;
    slot_take    = 1'b0;
    slot_free    = 1'b0;
    case (req_q)
      REQ_MAP: begin
        if (!mirror_hit) begin
          if (!dpres_q && !hasfree_q) begin
            res_status = ST_NOMEM;
          end else begin
            res_status  = ST_OK;
            u_tab_we    = 1'b1;
            u_tab_wdata = '{present: 1'b1, write: wr_q, user: user_q, frame: frame_q};
            if (!dpres_q) begin
              u_dir_we    = 1'b1;
              u_dir_wdata = '{present: 1'b1, write: 1'b1, user: user_q, slot: slot_q};
              slot_take   = 1'b1;
            end
            if (tab_ent.present) res_rel = 1'b1;
            else                 cnt_inc = 1'b1;
          end
        end
      end
      REQ_UNMAP: begin
        if (!mirror_hit && dpres_q && tab_ent.present) begin
          res_status = ST_OK;
          res_rel    = 1'b1;
          u_tab_we   = 1'b1;
          cnt_dec    = 1'b1;
          if (cnt_less == '0) begin
            slot_free = 1'b1;
            u_dir_we  = 1'b1;
          end
        end
      end
      REQ_XLATE: begin
        if (!mirror_hit && dpres_q && tab_ent.present) begin
          res_status   = ST_OK;
          res_mapped   = 1'b1;
          res_writable = dwrite_q & tab_ent.write;
          res_phys     = {tab_ent.frame, va_q[OFF_W-1:0]};
        end
      end
      default: ;
    endcase
  end

  // RAM ports
  logic              tab_we, dir_we;
  logic [TAB_AW-1:0] tab_waddr;
  logic [TAB_W-1:0]  tab_wdata;
  logic [DIR_AW-1:0] dir_waddr;
  logic [DIR_W-1:0]  dir_wdata;

  always_comb begin
    if (clearing_q) begin
      tab_we    = 1'b1;
      tab_waddr = clr_cnt_q;
      tab_wdata = '0;
      dir_we    = (clr_cnt_q[TAB_AW-1:DIR_AW] == '0);
      dir_waddr = clr_cnt_q[DIR_AW-1:0];
      dir_wdata = '0;
    end else begin
      tab_we    = go && u_tab_we;
      tab_waddr = {slot_q, ti};
      tab_wdata = u_tab_wdata;
      dir_we    = go && u_dir_we;
      dir_waddr = di;
      dir_wdata = u_dir_wdata;
    end
  end

  tlpt_ram #(.Width(DIR_W), .Depth(DIR_DEPTH)) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .re_i    (state_q == S_DIR),
    .raddr_i (di),
    .rdata_o (dir_rdata)
  );

  tlpt_ram #(.Width(TAB_W), .Depth(TAB_DEPTH)) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .re_i    (state_q == S_TAB),
    .raddr_i ({slot_sel, ti}),
    .rdata_o (tab_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) state_d = S_DIR;
      S_DIR:  state_d = S_TAB;
      S_TAB:  state_d = S_UPD;
      S_UPD:  if (go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE) && !clearing_q;
    cfg_ready_o = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mirror_q    <= MIRROR_RESET;
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      free_q      <= '1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TABLE_SLOTS; i++) cnt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) mirror_q <= cfg_data_i;
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + TAB_AW'(1);
        if (clr_cnt_q == '1) clearing_q <= 1'b0;
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (go) begin
        if (slot_take) free_q[slot_q] <= 1'b0;
        if (slot_free) free_q[slot_q] <= 1'b1;
        if (cnt_inc)   cnt_q[slot_q]  <= cnt_cur + CNT_W'(1);
        if (cnt_dec)   cnt_q[slot_q]  <= cnt_less;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q   <= req_type_i;
      va_q    <= virt_addr_i;
      frame_q <= page_frame_i;
      user_q  <= user_page_i;
      wr_q    <= write_allowed_i;
    end
    if (state_q == S_TAB) begin
      slot_q    <= slot_sel;
      dpres_q   <= dir_ent.present;
      dwrite_q  <= dir_ent.write;
      hasfree_q <= has_free;
    end
    if (go) begin
      status_q    <= res_status;
      mapped_q    <= res_mapped;
      writable_q  <= res_writable;
      phys_q      <= res_phys;
      rel_valid_q <= res_rel;
      rel_frame_q <= res_rel ? tab_ent.frame : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign mapped_o         = mapped_q;
  assign writable_o       = writable_q;
  assign phys_addr_o      = phys_q;
  assign released_valid_o = rel_valid_q;
  assign released_frame_o = rel_frame_q;

  a_no_req_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !in_ready_o) else $error("request accepted during clear");

  a_nomem_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && res_status == ST_NOMEM) |-> (free_q == '0))
    else $error("no-memory reported with a free slot");

  a_result_after_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> out_valid_q) else $error("update produced no result");

  a_take_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && slot_take) |-> free_q[slot_q]) else $error("allocated a busy slot");

endmodule

>>> test/tb_two_level_page_table_manager.sv
`timescale 1ns / 1ps
module tb_two_level_page_table_manager;
  import tlpt_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]         status;
    logic               mapped;
    logic               writable;
    logic [31:0]        phys_addr;
    logic               released_valid;
    logic [FRAME_W-1:0] released_frame;
  } page_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IDX_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] req_type_i = '0;
  logic [31:0] virt_addr_i = '0;
  logic [FRAME_W-1:0] page_frame_i = '0;
  logic user_page_i = 1'b0;
  logic write_allowed_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic mapped_o;
  logic writable_o;
  logic [31:0] phys_addr_o;
  logic released_valid_o;
  logic [FRAME_W-1:0] released_frame_o;

  two_level_page_table_manager u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .req_type_i, .virt_addr_i, .page_frame_i,
    .user_page_i, .write_allowed_i, .out_valid_o, .out_ready_i, .status_o,
    .mapped_o, .writable_o, .phys_addr_o, .released_valid_o, .released_frame_o
  );

  always #5 clk_i = ~clk_i;

  // shadow page table state
  logic [IDX_W-1:0] mirror_idx;
  dir_ent_t         dir_shadow [DIR_DEPTH];
  tab_ent_t         tab_shadow [TAB_DEPTH];
  int unsigned      slot_count [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] slot_free;

  page_result_t page_result_q[$];
  int  error_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic [IDX_W-1:0] dir_pool [20];
  logic [IDX_W-1:0] tab_pool [8];

  function automatic page_result_t walk_page_table(logic [1:0] req, logic [31:0] va,
                                                    logic [FRAME_W-1:0] frame,
                                                    logic user, logic wr);
    page_result_t r;
    logic [IDX_W-1:0] di;
    logic [IDX_W-1:0] ti;
    int s;
    int pos;
    r = '{ST_INVAL, 1'b0, 1'b0, 32'd0, 1'b0, '0};
    di = va[31:22];
    ti = va[21:12];
    s = -1;
    if (req == REQ_MAP && di != mirror_idx) begin
      if (!dir_shadow[di].present) begin
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
          if (slot_free[i]) s = i;
        if (s >= 0) begin
          slot_free[s] = 1'b0;
          for (int k = 0; k < ENTRIES_PER_TABLE; k++)
            tab_shadow[s * ENTRIES_PER_TABLE + k] = '0;
          slot_count[s] = 0;
          dir_shadow[di] = '{1'b1, 1'b1, user, s[SLOT_W-1:0]};
        end else begin
          r.status = ST_NOMEM;
        end
      end
      if (dir_shadow[di].present) begin
        pos = dir_shadow[di].slot * ENTRIES_PER_TABLE + ti;
        if (tab_shadow[pos].present) begin
          r.released_valid = 1'b1;
          r.released_frame = tab_shadow[pos].frame;
        end else begin
          slot_count[dir_shadow[di].slot]++;
        end
        tab_shadow[pos] = '{1'b1, wr, user, frame};
        r.status = ST_OK;
      end
    end else if (req == REQ_UNMAP && di != mirror_idx && dir_shadow[di].present) begin
      s = dir_shadow[di].slot;
      pos = s * ENTRIES_PER_TABLE + ti;
      if (tab_shadow[pos].present) begin
        r.released_valid = 1'b1;
        r.released_frame = tab_shadow[pos].frame;
        tab_shadow[pos] = '0;
        if (slot_count[s] > 0) slot_count[s]--;
        if (slot_count[s] == 0) begin
          slot_free[s] = 1'b1;
          dir_shadow[di] = '0;
        end
        r.status = ST_OK;
      end
    end else if (req == REQ_XLATE && di != mirror_idx && dir_shadow[di].present) begin
      pos = dir_shadow[di].slot * ENTRIES_PER_TABLE + ti;
      if (tab_shadow[pos].present) begin
        r.status = ST_OK;
        r.mapped = 1'b1;
        r.writable = dir_shadow[di].write & tab_shadow[pos].write;
        r.phys_addr = {tab_shadow[pos].frame, va[11:0]};
      end
    end
    return r;
  endfunction

  task automatic send_request(logic [1:0] req, logic [31:0] va, logic [FRAME_W-1:0] frame,
                              logic user, logic wr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    virt_addr_i     <= va;
    page_frame_i    <= frame;
    user_page_i     <= user;
    write_allowed_i <= wr;
    do @(posedge clk_i); while (!in_ready_o);
    page_result_q.push_back(walk_page_table(req, va, frame, user, wr));
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (page_result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mirror(logic [IDX_W-1:0] value);
    drain_requests();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror_idx = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] make_va(logic [IDX_W-1:0] di, logic [IDX_W-1:0] ti,
                                          logic [OFF_W-1:0] off);
    return {di, ti, off};
  endfunction

  task automatic test_directed();
    send_request(REQ_MAP, make_va(10'd0, 10'd0, 12'h000), 20'h00000, 1'b0, 1'b0);
    send_request(REQ_MAP, make_va(10'd1022, 10'd1023, 12'hfff), 20'hfffff, 1'b1, 1'b1);
    send_request(REQ_XLATE, make_va(10'd0, 10'd0, 12'hfff), '0, 1'b0, 1'b0);
    send_request(REQ_XLATE, make_va(10'd1022, 10'd1023, 12'h000), '0, 1'b0, 1'b0);
    send_request(REQ_XLATE, make_va(10'd1022, 10'd1023, 12'hfff), '0, 1'b1, 1'b1);
    // overwrite of a present entry
    send_request(REQ_MAP, make_va(10'd0, 10'd0, 12'h123), 20'h5a5a5, 1'b1, 1'b1);
    send_request(REQ_XLATE, make_va(10'd0, 10'd0, 12'h456), '0, 1'b0, 1'b0);
    send_request(REQ_MAP, make_va(10'd0, 10'd1, 12'h0), 20'h12345, 1'b0, 1'b1);
    send_request(REQ_UNMAP, make_va(10'd0, 10'd0, 12'h0), '0, 1'b0, 1'b0);
    send_request(REQ_UNMAP, make_va(10'd0, 10'd0, 12'h0), '0, 1'b0, 1'b0);
    send_request(REQ_XLATE, make_va(10'd0, 10'd0, 12'h0), '0, 1'b0, 1'b0);
    send_request(REQ_UNMAP, make_va(10'd0, 10'd1, 12'h0), '0, 1'b0, 1'b0);
    send_request(REQ_XLATE, make_va(10'd0, 10'd1, 12'h0), '0, 1'b0, 1'b0);
    send_request(REQ_UNMAP, make_va(10'd512, 10'd5, 12'h0), '0, 1'b0, 1'b0);
    send_request(REQ_UNKNOWN, 32'hffffffff, 20'hfffff, 1'b1, 1'b1);
    // reserved mirror index
    send_request(REQ_MAP, make_va(10'd1023, 10'd3, 12'h0), 20'h00001, 1'b1, 1'b1);
    send_request(REQ_UNMAP, make_va(10'd1023, 10'd3, 12'h0), '0, 1'b0, 1'b0);
    send_request(REQ_XLATE, make_va(10'd1023, 10'd3, 12'h0), '0, 1'b0, 1'b0);
  endtask

  task automatic test_slot_exhaustion();
    for (int i = 0; i < TABLE_SLOTS + 2; i++)
      send_request(REQ_MAP, make_va(10'(100 + i), 10'd7, 12'h0), 20'(i), 1'b0, 1'b1);
    send_request(REQ_XLATE, make_va(10'd117, 10'd7, 12'h0), '0, 1'b0, 1'b0);
    for (int i = 0; i < TABLE_SLOTS + 2; i++)
      send_request(REQ_UNMAP, make_va(10'(100 + i), 10'd7, 12'h0), '0, 1'b0, 1'b0);
  endtask

  task automatic test_random_phase(int items, int idle_pct, int stall_pct, bit pause_mid);
    logic [1:0] req;
    logic [31:0] va;
    int pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < 20; i++) dir_pool[i] = 10'($urandom_range(1023));
    dir_pool[19] = mirror_idx;
    for (int i = 0; i < 8; i++) tab_pool[i] = 10'($urandom_range(1023));
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) req = REQ_MAP;
      else if (pick < 65) req = REQ_UNMAP;
      else if (pick < 95) req = REQ_XLATE;
      else req = REQ_UNKNOWN;
      if ($urandom_range(99) < 85)
        va = make_va(dir_pool[$urandom_range(19)], tab_pool[$urandom_range(7)],
                     12'($urandom));
      else
        va = $urandom;
      if (pause_mid && n == items / 2) drain_requests();
      send_request(req, va, 20'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    page_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (page_result_q.size() == 0) begin
        $error("unexpected result, status %0d", status_o);
        error_count++;
      end else begin
        exp_r = page_result_q.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, status_o); error_count++;
        end
        if (mapped_o !== exp_r.mapped) begin
          $error("mapped exp %0d got %0d", exp_r.mapped, mapped_o); error_count++;
        end
        if (writable_o !== exp_r.writable) begin
          $error("writable exp %0d got %0d", exp_r.writable, writable_o); error_count++;
        end
        if (phys_addr_o !== exp_r.phys_addr) begin
          $error("phys_addr exp %h got %h", exp_r.phys_addr, phys_addr_o); error_count++;
        end
        if (released_valid_o !== exp_r.released_valid) begin
          $error("released_valid exp %0d got %0d", exp_r.released_valid, released_valid_o);
          error_count++;
        end
        if (released_frame_o !== exp_r.released_frame) begin
          $error("released_frame exp %h got %h", exp_r.released_frame, released_frame_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    mirror_idx = MIRROR_RESET;
    for (int i = 0; i < DIR_DEPTH; i++) dir_shadow[i] = '0;
    for (int i = 0; i < TAB_DEPTH; i++) tab_shadow[i] = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) slot_count[i] = 0;
    slot_free = '1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_slot_exhaustion();
    write_mirror(10'd0);
    send_request(REQ_MAP, make_va(10'd0, 10'd9, 12'h0), 20'h00abc, 1'b1, 1'b1);
    send_request(REQ_XLATE, make_va(10'd1023, 10'd1023, 12'h0), '0, 1'b0, 1'b0);
    test_random_phase(250, 0, 0, 1'b0);
    write_mirror(10'($urandom));
    test_random_phase(250, 85, 0, 1'b1);
    write_mirror(10'd1023);
    test_random_phase(250, 0, 85, 1'b0);
    write_mirror(10'($urandom));
    test_random_phase(250, 37, 37, 1'b0);

    drain_requests();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/core/tlpt_pkg.sv
rtl/core/tlpt_ram.sv
rtl/core/two_level_page_table_manager.sv
test/tb_two_level_page_table_manager.sv
